// File: rtl/i2c_mbe_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by i2c_mbe_seq and i2c_master_byte_engine_top.
package i2c_mbe_pkg;

   localparam int BYTE_BITS    = 8;
   localparam int TIMEOUT_BITS = 16;
   localparam int BIT_CNT_W    = 4;
   localparam int PHASE_W      = 3;
   localparam int OP_W         = 3;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = TIMEOUT_BITS;

   // operation codes
   localparam logic [OP_W-1:0] OP_START   = 3'd0;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
   localparam logic [OP_W-1:0] OP_RD_ACK  = 3'd3;
   localparam logic [OP_W-1:0] OP_RD_NACK = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUS_ENABLE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT = 1'd1;

   localparam logic [TIMEOUT_BITS-1:0] ACK_TIMEOUT_RESET = 16'd1000;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
   localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
   localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
   localparam logic [PHASE_W-1:0] PH_3 = 3'd3;
   localparam logic [PHASE_W-1:0] PH_4 = 3'd4;

   typedef struct packed {
      logic                 func;
      logic [OP_W-1:0]      op;
      logic [BYTE_BITS-1:0] wr_byte;
      logic                 sda_in;
   } req_type;

   typedef struct packed {
      logic                  wr_en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_release;
      logic                 busy_res;
      logic [BYTE_BITS-1:0] rd_byte;
      logic                 op_done;
      logic                 ack_error;
      logic                 refused;
   } rsp_type;

endpackage

// File: rtl/i2c_mbe_seq.sv
// Line sequencer of the I2C master byte engine: operation state, config
// registers and the one-beat phase step. Depends on i2c_mbe_pkg.
module i2c_mbe_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  i2c_mbe_pkg::req_type req,
   input  i2c_mbe_pkg::csr_type csr,
   output i2c_mbe_pkg::rsp_type result
);
   import i2c_mbe_pkg::*;

   logic                    bus_enable_ff;
   logic [TIMEOUT_BITS-1:0] ack_timeout_ff;

   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [BYTE_BITS-1:0]    shift_ff, shift_in;
   logic [OP_W-1:0]         cur_op_ff, cur_op_in;
   logic                    active_ff, active_in;
   logic                    scl_ff, scl_in;
   logic                    sda_drv_ff, sda_drv_in;
   logic [TIMEOUT_BITS-1:0] wait_cnt_ff, wait_cnt_in;
   logic [BYTE_BITS-1:0]    last_rd_ff, last_rd_in;

   logic                    done, err, refuse;
   logic [BIT_CNT_W-1:0]    bit_cnt_inc;

   assign bit_cnt_inc = bit_cnt_ff + 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      cur_op_in   = cur_op_ff;
      active_in   = active_ff;
      scl_in      = scl_ff;
      sda_drv_in  = sda_drv_ff;
      wait_cnt_in = wait_cnt_ff;
      last_rd_in  = last_rd_ff;
      done        = 1'b0;
      err         = 1'b0;
      refuse      = 1'b0;

      if (req.func) begin
         if (active_ff || req.op > OP_RD_NACK || (req.op == OP_START && !bus_enable_ff)) begin
            refuse = 1'b1;
         end else begin
            cur_op_in   = req.op;
            active_in   = 1'b1;
            phase_in    = PH_0;
            bit_cnt_in  = '0;
            wait_cnt_in = '0;
            shift_in    = (req.op == OP_WRITE) ? req.wr_byte : '0;
         end
      end else if (active_ff) begin
         case (cur_op_ff)
            OP_START: begin
               case (phase_ff)
                  PH_0: begin sda_drv_in = 1'b1; phase_in = PH_1; end
                  PH_1: begin scl_in = 1'b1; phase_in = PH_2; end
                  PH_2: begin sda_drv_in = 1'b0; phase_in = PH_3; end
                  default: begin
                     scl_in    = 1'b0;
                     active_in = 1'b0;
                     phase_in  = PH_0;
                     done      = 1'b1;
                  end
               endcase
            end
            OP_STOP: begin
               case (phase_ff)
                  PH_0: begin sda_drv_in = 1'b0; phase_in = PH_1; end
                  PH_1: begin scl_in = 1'b1; phase_in = PH_2; end
                  PH_2: begin scl_in = 1'b1; phase_in = PH_3; end
                  default: begin
                     sda_drv_in = 1'b1;
                     active_in  = 1'b0;
                     phase_in   = PH_0;
                     done       = 1'b1;
                  end
               endcase
            end
            OP_WRITE: begin
               case (phase_ff)
                  PH_0: begin
                     sda_drv_in = shift_ff[BYTE_BITS-1];
                     phase_in   = PH_1;
                  end
                  PH_1: begin scl_in = 1'b1; phase_in = PH_2; end
                  PH_2: begin
                     scl_in     = 1'b0;
                     shift_in   = {shift_ff[BYTE_BITS-2:0], 1'b0};
                     bit_cnt_in = bit_cnt_inc;
                     phase_in   = (bit_cnt_inc >= BIT_CNT_W'(BYTE_BITS)) ? PH_3 : PH_0;
                  end
                  PH_3: begin
                     sda_drv_in  = 1'b1;
                     scl_in      = 1'b1;
                     wait_cnt_in = '0;
                     phase_in    = PH_4;
                  end
                  default: begin
                     // ack wait: low means acknowledged
                     if (!req.sda_in) begin
                        scl_in    = 1'b0;
                        active_in = 1'b0;
                        phase_in  = PH_0;
                        done      = 1'b1;
                     end else if (wait_cnt_ff >= ack_timeout_ff) begin
                        active_in = 1'b0;
                        phase_in  = PH_0;
                        done      = 1'b1;
                        err       = 1'b1;
                     end else begin
                        wait_cnt_in = wait_cnt_ff + 1'b1;
                     end
                  end
               endcase
            end
            default: begin
               // reads with ACK or NACK
               case (phase_ff)
                  PH_0: begin
                     sda_drv_in = 1'b1;
                     scl_in     = 1'b1;
                     phase_in   = PH_1;
                  end
                  PH_1: begin
                     shift_in   = {shift_ff[BYTE_BITS-2:0], req.sda_in};
                     scl_in     = 1'b0;
                     bit_cnt_in = bit_cnt_inc;
                     phase_in   = (bit_cnt_inc >= BIT_CNT_W'(BYTE_BITS)) ? PH_2 : PH_0;
                  end
                  PH_2: begin
                     sda_drv_in = (cur_op_ff == OP_RD_ACK) ? 1'b0 : 1'b1;
                     phase_in   = PH_3;
                  end
                  PH_3: begin scl_in = 1'b1; phase_in = PH_4; end
                  default: begin
                     scl_in     = 1'b0;
                     last_rd_in = shift_ff;
                     active_in  = 1'b0;
                     phase_in   = PH_0;
                     done       = 1'b1;
                  end
               endcase
            end
         endcase
      end
   end

   always_comb begin
      result.scl_level   = scl_in;
      result.sda_release = sda_drv_in;
      result.busy_res    = active_in;
      result.rd_byte     = last_rd_in;
      result.op_done     = done;
      result.ack_error   = err;
      result.refused     = refuse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_enable_ff  <= 1'b1;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         phase_ff       <= PH_0;
         bit_cnt_ff     <= '0;
         shift_ff       <= '0;
         cur_op_ff      <= OP_START;
         active_ff      <= 1'b0;
         scl_ff         <= 1'b1;
         sda_drv_ff     <= 1'b1;
         wait_cnt_ff    <= '0;
         last_rd_ff     <= '0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            bit_cnt_ff  <= bit_cnt_in;
            shift_ff    <= shift_in;
            cur_op_ff   <= cur_op_in;
            active_ff   <= active_in;
            scl_ff      <= scl_in;
            sda_drv_ff  <= sda_drv_in;
            wait_cnt_ff <= wait_cnt_in;
            last_rd_ff  <= last_rd_in;
         end
         if (csr.wr_en && csr.index == CSR_BUS_ENABLE) begin
            bus_enable_ff <= csr.wdata[0];
            // disabling releases both lines and drops any operation
            if (!csr.wdata[0]) begin
               scl_ff     <= 1'b1;
               sda_drv_ff <= 1'b1;
               active_ff  <= 1'b0;
               phase_ff   <= PH_0;
            end
         end
         if (csr.wr_en && csr.index == CSR_ACK_TIMEOUT) begin
            ack_timeout_ff <= csr.wdata[TIMEOUT_BITS-1:0];
         end
      end
   end

endmodule

// File: rtl/i2c_master_byte_engine_top.sv
// I2C master byte engine, top level: ports, output register and skid stage.
// Depends on i2c_mbe_pkg and i2c_mbe_seq.
//
// Takes one beat per clock while req_stall is low: a command beat arms start,
// stop, byte write or byte read; each tick beat advances the armed operation
// by one bus phase. Every accepted beat yields exactly one result beat, held
// in the output register, or in the skid stage if that one is occupied. A
// second result can be parked in the skid stage, so req_stall rises only
// when both are full. Sustained rate is one beat per cycle while rsp_stall
// stays low. Config writes take effect at the edge they are presented.
module i2c_master_byte_engine_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [i2c_mbe_pkg::OP_W-1:0]        req_op,
   input  logic [i2c_mbe_pkg::BYTE_BITS-1:0]   req_wr_byte,
   input  logic                                req_sda_in,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_scl_level,
   output logic                                rsp_sda_release,
   output logic                                rsp_busy_res,
   output logic [i2c_mbe_pkg::BYTE_BITS-1:0]   rsp_rd_byte,
   output logic                                rsp_op_done,
   output logic                                rsp_ack_error,
   output logic                                rsp_refused,

   input  logic                                csr_wr_en,
   input  logic [i2c_mbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2c_mbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import i2c_mbe_pkg::*;

   req_type req;
   csr_type csr;
   rsp_type result;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_vld_ff, out_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   logic    accept, take;

   assign req.func    = req_func;
   assign req.op      = req_op;
   assign req.wr_byte = req_wr_byte;
   assign req.sda_in  = req_sda_in;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !skid_vld_ff;
   assign take      = out_vld_ff && !rsp_stall;

   i2c_mbe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .csr    (csr),
      .result (result)
   );

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (take) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = result;
            out_vld_in = accept;
         end
      end else if (!out_vld_ff) begin
         out_in     = result;
         out_vld_in = accept;
      end else if (accept) begin
         skid_in     = result;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_scl_level   = out_ff.scl_level;
   assign rsp_sda_release = out_ff.sda_release;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_rd_byte     = out_ff.rd_byte;
   assign rsp_op_done     = out_ff.op_done;
   assign rsp_ack_error   = out_ff.ack_error;
   assign rsp_refused     = out_ff.refused;

endmodule

// File: verif/i2c_master_byte_engine_top_test.sv
// Self-checking testbench for i2c_master_byte_engine_top: drives command and tick beats,
// predicts every result beat from a line-level model of the engine and compares field by field.
// Depends on i2c_mbe_pkg and the engine RTL only.
`timescale 1ns / 1ps

module i2c_master_byte_engine_top_test;
   import i2c_mbe_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_func;
   logic [OP_W-1:0]       req_op;
   logic [BYTE_BITS-1:0]  req_wr_byte;
   logic                  req_sda_in;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_scl_level;
   logic                  rsp_sda_release;
   logic                  rsp_busy_res;
   logic [BYTE_BITS-1:0]  rsp_rd_byte;
   logic                  rsp_op_done;
   logic                  rsp_ack_error;
   logic                  rsp_refused;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // engine model: configuration and line state
   logic                    cfg_enable    = 1'b1;
   logic [TIMEOUT_BITS-1:0] cfg_ack_limit = ACK_TIMEOUT_RESET;
   int                      bus_phase     = 0;
   int                      bit_idx       = 0;
   int                      ack_wait      = 0;
   logic [BYTE_BITS-1:0]    shift_reg     = '0;
   logic [BYTE_BITS-1:0]    last_rd_byte  = '0;
   logic [OP_W-1:0]         cur_op        = OP_START;
   logic                    op_active     = 1'b0;
   logic                    scl_drv       = 1'b1;
   logic                    sda_drv       = 1'b1;

   rsp_type line_result_q[$];
   int      error_count = 0;
   int      beat_count  = 0;
   bit      req_idle_on = 1'b1;
   bit      rsp_idle_on = 1'b1;
   int      ack_low_pct = 40;
   int      hold_req    = 0;
   int      hold_left   = 0;
   int      burst_left  = 0;

   i2c_master_byte_engine_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_op          (req_op),
      .req_wr_byte     (req_wr_byte),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_release (rsp_sda_release),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_rd_byte     (rsp_rd_byte),
      .rsp_op_done     (rsp_op_done),
      .rsp_ack_error   (rsp_ack_error),
      .rsp_refused     (rsp_refused),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // advances the model by one beat and returns the line state it should report
   function automatic rsp_type predict_line_state(req_type beat);
      rsp_type res;
      res = '0;
      if (beat.func) begin
         if (op_active || beat.op > OP_RD_NACK || (beat.op == OP_START && !cfg_enable)) begin
            res.refused = 1'b1;
         end else begin
            cur_op    = beat.op;
            op_active = 1'b1;
            bus_phase = 0;
            bit_idx   = 0;
            ack_wait  = 0;
            shift_reg = (beat.op == OP_WRITE) ? beat.wr_byte : '0;
         end
      end else if (op_active) begin
         case (cur_op)
            OP_START: begin
               case (bus_phase)
                  0: sda_drv = 1'b1;
                  1: scl_drv = 1'b1;
                  2: sda_drv = 1'b0;
                  default: begin
                     scl_drv     = 1'b0;
                     op_active   = 1'b0;
                     res.op_done = 1'b1;
                  end
               endcase
               bus_phase = op_active ? bus_phase + 1 : 0;
            end
            OP_STOP: begin
               case (bus_phase)
                  0: sda_drv = 1'b0;
                  1, 2: scl_drv = 1'b1;
                  default: begin
                     sda_drv     = 1'b1;
                     op_active   = 1'b0;
                     res.op_done = 1'b1;
                  end
               endcase
               bus_phase = op_active ? bus_phase + 1 : 0;
            end
            OP_WRITE: begin
               case (bus_phase)
                  0: begin
                     sda_drv   = shift_reg[BYTE_BITS-1];
                     bus_phase = 1;
                  end
                  1: begin
                     scl_drv   = 1'b1;
                     bus_phase = 2;
                  end
                  2: begin
                     scl_drv   = 1'b0;
                     shift_reg = shift_reg << 1;
                     bit_idx++;
                     bus_phase = (bit_idx >= BYTE_BITS) ? 3 : 0;
                  end
                  3: begin
                     sda_drv   = 1'b1;
                     scl_drv   = 1'b1;
                     ack_wait  = 0;
                     bus_phase = 4;
                  end
                  default: begin
                     if (!beat.sda_in) begin
                        scl_drv     = 1'b0;
                        op_active   = 1'b0;
                        bus_phase   = 0;
                        res.op_done = 1'b1;
                     end else if (ack_wait >= cfg_ack_limit) begin
                        // no acknowledge: abort with SCL left high
                        op_active     = 1'b0;
                        bus_phase     = 0;
                        res.op_done   = 1'b1;
                        res.ack_error = 1'b1;
                     end else begin
                        ack_wait++;
                     end
                  end
               endcase
            end
            default: begin
               case (bus_phase)
                  0: begin
                     sda_drv   = 1'b1;
                     scl_drv   = 1'b1;
                     bus_phase = 1;
                  end
                  1: begin
                     shift_reg = {shift_reg[BYTE_BITS-2:0], beat.sda_in};
                     scl_drv   = 1'b0;
                     bit_idx++;
                     bus_phase = (bit_idx >= BYTE_BITS) ? 2 : 0;
                  end
                  2: begin
                     sda_drv   = (cur_op == OP_RD_ACK) ? 1'b0 : 1'b1;
                     bus_phase = 3;
                  end
                  3: begin
                     scl_drv   = 1'b1;
                     bus_phase = 4;
                  end
                  default: begin
                     scl_drv      = 1'b0;
                     last_rd_byte = shift_reg;
                     op_active    = 1'b0;
                     bus_phase    = 0;
                     res.op_done  = 1'b1;
                  end
               endcase
            end
         endcase
      end
      res.scl_level   = scl_drv;
      res.sda_release = sda_drv;
      res.busy_res    = op_active;
      res.rd_byte     = last_rd_byte;
      return res;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // result side: compare each accepted beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_result_q.size() == 0) begin
            $error("result beat with nothing predicted");
            error_count++;
         end else begin
            want = line_result_q.pop_front();
            check_field("scl_level", 8'(want.scl_level), 8'(rsp_scl_level));
            check_field("sda_release", 8'(want.sda_release), 8'(rsp_sda_release));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
            check_field("rd_byte", want.rd_byte, rsp_rd_byte);
            check_field("op_done", 8'(want.op_done), 8'(rsp_op_done));
            check_field("ack_error", 8'(want.ack_error), 8'(rsp_ack_error));
            check_field("refused", 8'(want.refused), 8'(rsp_refused));
         end
      end
   end

   // result stall: long hold-offs on request, otherwise short random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left != 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // valid stays high after acceptance; the caller sends again or goes idle in the same step
   task automatic send_beat(input logic func, input logic [OP_W-1:0] op,
                            input logic [BYTE_BITS-1:0] wr, input logic sda);
      req_type beat;
      beat = '{func: func, op: op, wr_byte: wr, sda_in: sda};
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_op      <= op;
      req_wr_byte <= wr;
      req_sda_in  <= sda;
      do @(posedge clock); while (req_stall);
      line_result_q.push_back(predict_line_state(beat));
      beat_count++;
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (line_result_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      settle_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_BUS_ENABLE) begin
         cfg_enable = data[0];
         if (!data[0]) begin
            // disabling releases both lines and drops the current operation
            scl_drv   = 1'b1;
            sda_drv   = 1'b1;
            op_active = 1'b0;
            bus_phase = 0;
         end
      end else begin
         cfg_ack_limit = data;
      end
   endtask

   // arms one operation and ticks it to completion; refused busy commands mixed in at noise_pct
   task automatic run_bus_op(input logic [OP_W-1:0] op, input logic [BYTE_BITS-1:0] wr,
                             input logic [BYTE_BITS-1:0] rd_bits, input int ack_pct,
                             input int noise_pct);
      logic sda;
      send_beat(1'b1, op, wr, 1'($urandom_range(0, 1)));
      while (op_active) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_beat(1'b1, OP_W'($urandom_range(0, 7)), BYTE_BITS'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         end else begin
            sda = 1'($urandom_range(0, 1));
            if (cur_op == OP_WRITE && bus_phase == 4)
               sda = ($urandom_range(0, 99) >= ack_pct);
            else if ((cur_op == OP_RD_ACK || cur_op == OP_RD_NACK) && bus_phase == 1)
               sda = rd_bits[BYTE_BITS-1-bit_idx];
            send_beat(1'b0, OP_W'($urandom_range(0, 7)), BYTE_BITS'($urandom_range(0, 255)),
                      sda);
         end
      end
   endtask

   // start, address byte, a few data bytes (reads end with NACK), stop
   task automatic run_transaction(input int noise_pct);
      int  n_bytes;
      bit  is_read;
      run_bus_op(OP_START, BYTE_BITS'($urandom), BYTE_BITS'($urandom), ack_low_pct, noise_pct);
      run_bus_op(OP_WRITE, BYTE_BITS'($urandom), BYTE_BITS'($urandom), ack_low_pct, noise_pct);
      n_bytes = $urandom_range(1, 3);
      is_read = 1'($urandom_range(0, 1));
      for (int i = 0; i < n_bytes; i++) begin
         if (is_read)
            run_bus_op((i == n_bytes - 1) ? OP_RD_NACK : OP_RD_ACK, BYTE_BITS'($urandom),
                       BYTE_BITS'($urandom), ack_low_pct, noise_pct);
         else
            run_bus_op(OP_WRITE, BYTE_BITS'($urandom), BYTE_BITS'($urandom), ack_low_pct,
                       noise_pct);
      end
      run_bus_op(OP_STOP, BYTE_BITS'($urandom), BYTE_BITS'($urandom), ack_low_pct, noise_pct);
   endtask

   task automatic test_directed_ops();
      send_beat(1'b0, 3'd7, 8'hFF, 1'b1);   // tick with nothing armed
      send_beat(1'b1, 3'd5, 8'h00, 1'b0);
      send_beat(1'b1, 3'd6, 8'hFF, 1'b1);
      send_beat(1'b1, 3'd7, 8'h55, 1'b0);
      run_bus_op(OP_START, 8'h00, 8'h00, 100, 0);
      run_bus_op(OP_WRITE, 8'hFF, 8'h00, 100, 10);
      run_bus_op(OP_WRITE, 8'h00, 8'h00, 50, 0);
      run_bus_op(OP_RD_ACK, 8'h00, 8'hFF, 100, 0);
      run_bus_op(OP_RD_NACK, 8'h00, 8'h00, 100, 0);
      run_bus_op(OP_RD_ACK, 8'h00, 8'h5A, 100, 10);
      run_bus_op(OP_STOP, 8'h00, 8'h00, 100, 0);
   endtask

   task automatic test_bus_enable();
      write_csr(CSR_BUS_ENABLE, 16'hFFFE);
      send_beat(1'b1, OP_START, 8'hFF, 1'b1);
      run_bus_op(OP_STOP, 8'h00, 8'h00, 100, 0);
      run_bus_op(OP_WRITE, 8'h3C, 8'h00, 100, 0);
      run_bus_op(OP_RD_NACK, 8'h00, 8'hC3, 100, 0);
      write_csr(CSR_BUS_ENABLE, 16'hFFFF);
      run_bus_op(OP_START, 8'h00, 8'h00, 100, 0);
      // disable part way through a read
      send_beat(1'b1, OP_RD_ACK, 8'h00, 1'b0);
      repeat (5) send_beat(1'b0, OP_START, 8'h00, 1'b1);
      write_csr(CSR_BUS_ENABLE, 16'h0000);
      send_beat(1'b0, OP_STOP, 8'h00, 1'b0);
      write_csr(CSR_BUS_ENABLE, 16'h0001);
   endtask

   task automatic test_ack_timeout();
      write_csr(CSR_ACK_TIMEOUT, 16'h0000);
      run_bus_op(OP_WRITE, 8'hA5, 8'h00, 0, 0);
      write_csr(CSR_ACK_TIMEOUT, 16'd3);
      run_bus_op(OP_WRITE, 8'h5A, 8'h00, 0, 0);
      write_csr(CSR_ACK_TIMEOUT, 16'hFFFF);
      run_bus_op(OP_WRITE, BYTE_BITS'($urandom), 8'h00, 40, 0);
   endtask

   task automatic test_random_traffic(input int n_beats);
      int stop_at;
      int pick;
      stop_at = beat_count + n_beats;
      while (beat_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            run_transaction(2);
         else if (pick < 85)
            run_bus_op(OP_W'($urandom_range(0, 4)), BYTE_BITS'($urandom),
                       BYTE_BITS'($urandom), ack_low_pct, 5);
         else
            repeat ($urandom_range(1, 4))
               send_beat(1'($urandom_range(0, 1)), OP_W'($urandom_range(0, 7)),
                         BYTE_BITS'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_configs();
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               write_csr(CSR_ACK_TIMEOUT, ACK_TIMEOUT_RESET);
               ack_low_pct = 40;
            end
            1: begin
               write_csr(CSR_ACK_TIMEOUT, CSR_DATA_W'($urandom_range(0, 6)));
               ack_low_pct = 20;
            end
            2: begin
               write_csr(CSR_BUS_ENABLE, {15'($urandom_range(0, 32767)), 1'b0});
               write_csr(CSR_ACK_TIMEOUT, CSR_DATA_W'($urandom_range(1, 20)));
               ack_low_pct = 30;
            end
            3: begin
               write_csr(CSR_BUS_ENABLE, {15'($urandom_range(0, 32767)), 1'b1});
               write_csr(CSR_ACK_TIMEOUT, 16'hFFFF);
               ack_low_pct = 50;
            end
            default: begin
               write_csr(CSR_ACK_TIMEOUT, CSR_DATA_W'($urandom_range(0, 65535)));
               ack_low_pct = 35;
            end
         endcase
         test_random_traffic(200);
      end
   endtask

   // result side held off long enough for the engine to fill and stall its input
   task automatic test_backpressure();
      write_csr(CSR_ACK_TIMEOUT, 16'd8);
      hold_req = 64;
      run_transaction(0);
      run_transaction(0);
   endtask

   task automatic test_steady_stream();
      settle_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(150);
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_func    <= 1'b0;
      req_op      <= OP_START;
      req_wr_byte <= '0;
      req_sda_in  <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_BUS_ENABLE;
      csr_wdata   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_bus_enable();
      test_ack_timeout();
      test_random_configs();
      test_backpressure();
      test_steady_stream();
      req_valid <= 1'b0;
      while (line_result_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
